// File: rtl/ttdp_pkg.sv
// Shared types, codes and constants for the touch tap/drag to pointer core.
// Used by every module under rtl; depends on nothing else.
package ttdp_pkg;

	// Result count per item and default depth of the front-to-back queue.
	localparam int MAX_RESULTS   = 4;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CNT_W         = 3;
	localparam int SLOT_W        = 2;

	// Field widths fixed by the interface.
	localparam int PX_W          = 15;
	localparam int FRAC_W        = 17;
	localparam int TIME_W        = 32;
	localparam int REL_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	// Input function codes.
	typedef enum logic [2:0] {
		FUNC_DOWN   = 3'd0,
		FUNC_UP     = 3'd1,
		FUNC_MOTION = 3'd2,
		FUNC_REL    = 3'd3,
		FUNC_ENTER  = 3'd4
	} func_t;

	// Result kind codes.
	typedef enum logic [1:0] {
		KIND_MOTION  = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_ENTER   = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_ROTATED  = 3'd2,
		REG_FOCUS    = 3'd3,
		REG_TAP_RAD  = 3'd4,
		REG_TAP_TIME = 3'd5,
		REG_HOLD     = 3'd6,
		REG_SLOP     = 3'd7
	} cfg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [PX_W-1:0] width;
		logic [PX_W-1:0] height;
		logic            rotated;
		logic            focus;
		logic [13:0]     tap_radius;
		logic [15:0]     tap_time;
		logic [15:0]     hold_time;
		logic [13:0]     slop_radius;
	} cfg_t;

	// One classified item: up to four results, each at the down point or the cursor.
	typedef struct packed {
		logic [CNT_W-1:0]                cnt;
		kind_t [MAX_RESULTS-1:0]         kinds;
		logic [MAX_RESULTS-1:0]          at_down;
		logic [PX_W-1:0]                 down_x;
		logic [PX_W-1:0]                 down_y;
		logic [PX_W-1:0]                 cur_x;
		logic [PX_W-1:0]                 cur_y;
		logic [TIME_W-1:0]               stamp;
	} entry_t;

endpackage

// File: rtl/touch_tap_drag_to_pointer_core.sv
// Touch tap/drag to pointer core. Touch and relative mouse items come in on the
// in_valid/in_ready channel and leave as pointer results (motion, left press,
// left release, pointer enter) on out_valid/out_ready, each item giving zero
// to four results with last set on the final one. The front end takes one item
// per clock while its queue has room; an item is registered in stage one when
// accepted, then written to the queue, and its results are loaded in turn from
// the queue head into the output register, which gives one result per clock
// while out_ready is high and so sets the sustained rate. Items that give no
// result pass through the front end only. Registers are written on the cfg
// channel, which is always ready; the user must write them only while the core
// is idle, which the core does not enforce.
// Depends on ttdp_pkg, ttdp_cfg, ttdp_front, ttdp_queue and ttdp_back.
module touch_tap_drag_to_pointer_core
	import ttdp_pkg::*;
#(
	parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              func,
	input  logic [TIME_W-1:0]       now_ms,
	input  logic [TIME_W-1:0]       event_time,
	input  logic [FRAC_W-1:0]       touch_x,
	input  logic [FRAC_W-1:0]       touch_y,
	input  logic signed [REL_W-1:0] rel_dx,
	input  logic signed [REL_W-1:0] rel_dy,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic [PX_W-1:0]         cursor_x,
	output logic [PX_W-1:0]         cursor_y,
	output logic [TIME_W-1:0]       stamp,
	output logic                    last
);

	cfg_t   cfg;
	logic   q_full, q_empty, q_push, q_pop;
	entry_t q_in, q_head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	ttdp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Accept and classify items.
	ttdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.now_ms     (now_ms),
		.event_time (event_time),
		.touch_x    (touch_x),
		.touch_y    (touch_y),
		.rel_dx     (rel_dx),
		.rel_dy     (rel_dy),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_in)
	);

	// Queue between the two halves.
	ttdp_queue #(
		.DEPTH (QUEUE_ENTRIES)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	// Deliver results.
	ttdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.cursor_x  (cursor_x),
		.cursor_y  (cursor_y),
		.stamp     (stamp),
		.last      (last)
	);

endmodule

// File: rtl/ttdp_cfg.sv
// Configuration register file for the touch tap/drag to pointer core.
// Depends on ttdp_pkg for the register indexes and the cfg_t struct.
module ttdp_cfg
	import ttdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Registers take their reset values and are written one at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width       <= 15'd1280;
			cfg_q.height      <= 15'd800;
			cfg_q.rotated     <= 1'b0;
			cfg_q.focus       <= 1'b0;
			cfg_q.tap_radius  <= 14'd50;
			cfg_q.tap_time    <= 16'd100;
			cfg_q.hold_time   <= 16'd200;
			cfg_q.slop_radius <= 14'd100;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH:    cfg_q.width       <= wr_data[PX_W-1:0];
				REG_HEIGHT:   cfg_q.height      <= wr_data[PX_W-1:0];
				REG_ROTATED:  cfg_q.rotated     <= wr_data[0];
				REG_FOCUS:    cfg_q.focus       <= wr_data[0];
				REG_TAP_RAD:  cfg_q.tap_radius  <= wr_data[13:0];
				REG_TAP_TIME: cfg_q.tap_time    <= wr_data;
				REG_HOLD:     cfg_q.hold_time   <= wr_data;
				REG_SLOP:     cfg_q.slop_radius <= wr_data[13:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ttdp_front.sv
// Front end: accepts items, maps touch positions, keeps the gesture state and
// turns each item that gives a result into one queue entry. Depends on ttdp_pkg.
module ttdp_front
	import ttdp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               func,
	input  logic [TIME_W-1:0]        now_ms,
	input  logic [TIME_W-1:0]        event_time,
	input  logic [FRAC_W-1:0]        touch_x,
	input  logic [FRAC_W-1:0]        touch_y,
	input  logic signed [REL_W-1:0]  rel_dx,
	input  logic signed [REL_W-1:0]  rel_dy,
	input  logic                     q_full,
	output logic                     push,
	output entry_t                   push_entry
);

	function automatic logic [PX_W-1:0] absdiff(input logic [PX_W-1:0] a,
	                                            input logic [PX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Adds a signed move to a position and clamps it into [0, size - 1].
	function automatic logic [PX_W-1:0] clamp_move(input logic [PX_W-1:0] pos,
	                                               input logic signed [REL_W-1:0] d,
	                                               input logic [PX_W-1:0] size);
		logic signed [PX_W+2:0] v;
		logic signed [PX_W+2:0] hi;
		v  = $signed({3'b000, pos}) + $signed({{2{d[REL_W-1]}}, d});
		hi = $signed({3'b000, size}) - $signed(18'sd1);
		if (v > hi) v = hi;
		if (v < $signed(18'sd0)) v = '0;
		return v[PX_W-1:0];
	endfunction

	logic accept;
	logic fire;

	logic [FRAC_W-1:0] tx_sat, ty_sat, fx, fy;
	logic [31:0]       prod_x, prod_y;

	logic                    valid_s1;
	logic [2:0]              func_s1;
	logic [TIME_W-1:0]       now_s1;
	logic [TIME_W-1:0]       stamp_s1;
	logic [PX_W-1:0]         px_s1, py_s1;
	logic signed [REL_W-1:0] dx_s1, dy_s1;

	logic [PX_W-1:0]   cursor_x_q, cursor_y_q, down_x_q, down_y_q;
	logic [TIME_W-1:0] down_time_q;
	logic              drag_active_q, drag_allowed_q;

	logic [PX_W-1:0]   cursor_x_d, cursor_y_d, down_x_d, down_y_d;
	logic [TIME_W-1:0] down_time_d;
	logic              drag_active_d, drag_allowed_d;

	logic [TIME_W-1:0] since;
	logic              is_tap, past_hold, past_slop;
	entry_t            ent;

	// The entry stage moves on whenever the queue has room.
	assign fire     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign accept   = in_valid && in_ready;

	// Touch mapping: saturate, optionally rotate, then scale to pixels.
	always_comb begin
		tx_sat = (touch_x > FRAC_ONE) ? FRAC_ONE : touch_x;
		ty_sat = (touch_y > FRAC_ONE) ? FRAC_ONE : touch_y;
		fx     = cfg.rotated ? ty_sat : tx_sat;
		fy     = cfg.rotated ? (FRAC_ONE - tx_sat) : ty_sat;
		prod_x = 32'(fx) * 32'(cfg.width);
		prod_y = 32'(fy) * 32'(cfg.height);
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			now_s1   <= now_ms;
			stamp_s1 <= event_time;
			px_s1    <= prod_x[16 +: PX_W];
			py_s1    <= prod_y[16 +: PX_W];
			dx_s1    <= rel_dx;
			dy_s1    <= rel_dy;
		end
	end

	// Gesture decisions for the item in stage one.
	always_comb begin
		since     = now_s1 - down_time_q;
		is_tap    = (absdiff(cursor_x_q, down_x_q) < {1'b0, cfg.tap_radius}) &&
		            (absdiff(cursor_y_q, down_y_q) < {1'b0, cfg.tap_radius}) &&
		            (since < {16'd0, cfg.tap_time});
		past_hold = (since > {16'd0, cfg.hold_time}) || !drag_allowed_q;
		past_slop = (absdiff(px_s1, down_x_q) > {1'b0, cfg.slop_radius}) ||
		            (absdiff(py_s1, down_y_q) > {1'b0, cfg.slop_radius});
	end

	// Next state and the queue entry for the item in stage one.
	always_comb begin
		cursor_x_d     = cursor_x_q;
		cursor_y_d     = cursor_y_q;
		down_x_d       = down_x_q;
		down_y_d       = down_y_q;
		down_time_d    = down_time_q;
		drag_active_d  = drag_active_q;
		drag_allowed_d = drag_allowed_q;
		ent.cnt        = '0;
		ent.kinds      = '{default: KIND_MOTION};
		ent.at_down    = '0;

		case (func_s1)
			FUNC_ENTER: begin
				cursor_x_d   = cfg.width >> 1;
				cursor_y_d   = cfg.height >> 1;
				ent.cnt      = 3'd1;
				ent.kinds[0] = KIND_ENTER;
			end
			FUNC_DOWN: begin
				if (cfg.focus) begin
					cursor_x_d     = px_s1;
					cursor_y_d     = py_s1;
					down_x_d       = px_s1;
					down_y_d       = py_s1;
					down_time_d    = now_s1;
					drag_active_d  = 1'b0;
					drag_allowed_d = 1'b1;
					ent.cnt        = 3'd1;
				end
			end
			FUNC_UP: begin
				if (cfg.focus) begin
					drag_active_d = 1'b0;
					if (is_tap) begin
						ent.cnt        = 3'd3;
						ent.kinds[1]   = KIND_PRESS;
						ent.kinds[2]   = KIND_RELEASE;
						ent.at_down    = 4'b0111;
						if (drag_active_q) begin
							ent.cnt      = 3'd4;
							ent.kinds[3] = KIND_RELEASE;
						end
					end else if (drag_active_q) begin
						ent.cnt      = 3'd1;
						ent.kinds[0] = KIND_RELEASE;
					end
				end
			end
			FUNC_MOTION: begin
				if (cfg.focus) begin
					if (past_hold) begin
						cursor_x_d = px_s1;
						cursor_y_d = py_s1;
						if (drag_allowed_q) begin
							// Hold time passed: press at the down point, then follow.
							drag_allowed_d = 1'b0;
							drag_active_d  = 1'b1;
							ent.cnt        = 3'd3;
							ent.kinds[1]   = KIND_PRESS;
							ent.at_down    = 4'b0011;
						end else begin
							ent.cnt = 3'd1;
						end
					end else if (past_slop) begin
						drag_allowed_d = 1'b0;
					end
				end
			end
			FUNC_REL: begin
				if (cfg.focus) begin
					cursor_x_d = clamp_move(cursor_x_q, dx_s1, cfg.width);
					cursor_y_d = clamp_move(cursor_y_q, dy_s1, cfg.height);
					ent.cnt    = 3'd1;
				end
			end
			default: ;
		endcase

		ent.down_x = down_x_q;
		ent.down_y = down_y_q;
		ent.cur_x  = cursor_x_d;
		ent.cur_y  = cursor_y_d;
		ent.stamp  = stamp_s1;
	end

	// Gesture state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			down_x_q       <= '0;
			down_y_q       <= '0;
			down_time_q    <= '0;
			drag_active_q  <= 1'b0;
			drag_allowed_q <= 1'b0;
		end else if (fire) begin
			cursor_x_q     <= cursor_x_d;
			cursor_y_q     <= cursor_y_d;
			down_x_q       <= down_x_d;
			down_y_q       <= down_y_d;
			down_time_q    <= down_time_d;
			drag_active_q  <= drag_active_d;
			drag_allowed_q <= drag_allowed_d;
		end
	end

	// Items that give no result never enter the queue.
	assign push       = fire && (ent.cnt != '0);
	assign push_entry = ent;

endmodule

// File: rtl/ttdp_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on ttdp_pkg for the entry_t struct.
module ttdp_queue
	import ttdp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	entry_t            slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/ttdp_back.sv
// Back end: walks the results of the head queue entry into the output register,
// one a cycle while that register is free or being taken. Depends on ttdp_pkg.
module ttdp_back
	import ttdp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  entry_t            head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [PX_W-1:0]   cursor_x,
	output logic [PX_W-1:0]   cursor_y,
	output logic [TIME_W-1:0] stamp,
	output logic              last
);

	logic [SLOT_W-1:0] slot_q;
	logic              out_valid_q;
	logic              load;
	logic              is_last;

	logic [1:0]        kind_q;
	logic [PX_W-1:0]   x_q, y_q;
	logic [TIME_W-1:0] stamp_q;
	logic              last_q;

	// A result is loaded whenever the queue holds an entry and the output register is free or being taken.
	assign load    = !empty && (!out_valid_q || out_ready);
	assign is_last = ({1'b0, slot_q} == (head.cnt - 3'd1));
	assign pop     = load && is_last;

	// Control: output valid and the result slot within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			slot_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				slot_q      <= is_last ? '0 : slot_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= head.kinds[slot_q];
			x_q     <= head.at_down[slot_q] ? head.down_x : head.cur_x;
			y_q     <= head.at_down[slot_q] ? head.down_y : head.cur_y;
			stamp_q <= head.stamp;
			last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign cursor_x  = x_q;
	assign cursor_y  = y_q;
	assign stamp     = stamp_q;
	assign last      = last_q;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for touch_tap_drag_to_pointer_core: tap, drag, relative and enter items.
// Depends on ttdp_pkg and the core; predicts each pointer result and checks it in order.
module tb_top;
	import ttdp_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 150;
	localparam cfg_t RESET_SETTINGS = '{width: 15'd1280, height: 15'd800, rotated: 1'b0,
		focus: 1'b0, tap_radius: 14'd50, tap_time: 16'd100, hold_time: 16'd200,
		slop_radius: 14'd100};

	// One expected pointer result.
	typedef struct packed {
		kind_t       kind;
		logic [14:0] x;
		logic [14:0] y;
		logic [31:0] stamp;
		logic        last;
	} pointer_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              func = '0;
	logic [TIME_W-1:0]       now_ms = '0;
	logic [TIME_W-1:0]       event_time = '0;
	logic [FRAC_W-1:0]       touch_x = '0;
	logic [FRAC_W-1:0]       touch_y = '0;
	logic signed [REL_W-1:0] rel_dx = '0;
	logic signed [REL_W-1:0] rel_dy = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              kind;
	logic [PX_W-1:0]         cursor_x;
	logic [PX_W-1:0]         cursor_y;
	logic [TIME_W-1:0]       stamp;
	logic                    last;

	// Predictor copy of the registers and of the gesture state.
	cfg_t        settings = RESET_SETTINGS;
	logic [14:0] cur_x = '0;
	logic [14:0] cur_y = '0;
	logic [14:0] down_x = '0;
	logic [14:0] down_y = '0;
	logic [31:0] down_t = '0;
	logic        drag_on = 1'b0;
	logic        drag_ok = 1'b0;

	pointer_result_t expected_pointer[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 22;
	int          recv_idle_pct = 47;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	logic [31:0] clock_ms = 32'd100000;

	touch_tap_drag_to_pointer_core dut (.*);

	always #4 clk = ~clk;

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off when a test asks for it.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		pointer_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pointer.size() == 0) begin
				$error("result with nothing expected: kind %0d at (%0d,%0d)",
					kind, cursor_x, cursor_y);
				mismatches++;
			end else begin
				want = expected_pointer.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("cursor_x", 32'(want.x), 32'(cursor_x));
				check_field("cursor_y", 32'(want.y), 32'(cursor_y));
				check_field("stamp", want.stamp, stamp);
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	function automatic pointer_result_t make_result(kind_t k, logic [14:0] x, logic [14:0] y,
		logic [31:0] st);
		pointer_result_t r;
		r.kind = k;
		r.x = x;
		r.y = y;
		r.stamp = st;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [14:0] px_gap(logic [14:0] a, logic [14:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Saturate the fractions, rotate if asked, then scale to pixels with truncation.
	function automatic void map_touch(input logic [16:0] tx, input logic [16:0] ty,
		output logic [14:0] px, output logic [14:0] py);
		logic [16:0] sx, sy, fx, fy;
		logic [47:0] prod_x, prod_y;
		sx = (tx > FRAC_ONE) ? FRAC_ONE : tx;
		sy = (ty > FRAC_ONE) ? FRAC_ONE : ty;
		fx = settings.rotated ? sy : sx;
		fy = settings.rotated ? FRAC_ONE - sx : sy;
		prod_x = 48'(fx) * 48'(settings.width);
		prod_y = 48'(fy) * 48'(settings.height);
		px = prod_x[30:16];
		py = prod_y[30:16];
	endfunction

	// Relative move, clamped to the surface.
	function automatic logic [14:0] clamp_px(logic [14:0] pos, logic [15:0] d, logic [14:0] size);
		int v, hi;
		hi = int'(size) - 1;
		v = int'(pos) + int'($signed(d));
		if (v > hi)
			v = hi;
		if (v < 0)
			v = 0;
		return v[14:0];
	endfunction

	// Work out the pointer results of one accepted item and update the gesture state.
	task automatic predict_pointer(input logic [2:0] f, input logic [31:0] now,
		input logic [31:0] evt, input logic [16:0] tx, input logic [16:0] ty,
		input logic [15:0] dx, input logic [15:0] dy);
		pointer_result_t batch[$];
		pointer_result_t tail;
		logic [14:0] px, py;
		logic [31:0] since;
		since = now - down_t;
		if (f == FUNC_ENTER) begin
			cur_x = settings.width >> 1;
			cur_y = settings.height >> 1;
			batch.push_back(make_result(KIND_ENTER, cur_x, cur_y, evt));
		end else if (f <= FUNC_REL && settings.focus) begin
			case (f)
			FUNC_DOWN: begin
				map_touch(tx, ty, px, py);
				cur_x = px;
				cur_y = py;
				down_x = px;
				down_y = py;
				down_t = now;
				drag_on = 1'b0;
				drag_ok = 1'b1;
				batch.push_back(make_result(KIND_MOTION, cur_x, cur_y, evt));
			end
			FUNC_UP: begin
				// A short, quick touch is a click at the down point.
				if (px_gap(cur_x, down_x) < settings.tap_radius &&
					px_gap(cur_y, down_y) < settings.tap_radius &&
					since < settings.tap_time) begin
					batch.push_back(make_result(KIND_MOTION, down_x, down_y, evt));
					batch.push_back(make_result(KIND_PRESS, down_x, down_y, evt));
					batch.push_back(make_result(KIND_RELEASE, down_x, down_y, evt));
				end
				if (drag_on)
					batch.push_back(make_result(KIND_RELEASE, cur_x, cur_y, evt));
				drag_on = 1'b0;
			end
			FUNC_MOTION: begin
				map_touch(tx, ty, px, py);
				if (since > settings.hold_time || !drag_ok) begin
					// The first motion past the hold time starts the drag.
					if (drag_ok) begin
						drag_ok = 1'b0;
						drag_on = 1'b1;
						batch.push_back(make_result(KIND_MOTION, down_x, down_y, evt));
						batch.push_back(make_result(KIND_PRESS, down_x, down_y, evt));
					end
					cur_x = px;
					cur_y = py;
					batch.push_back(make_result(KIND_MOTION, cur_x, cur_y, evt));
				end else if (px_gap(px, down_x) > settings.slop_radius ||
					px_gap(py, down_y) > settings.slop_radius)
					drag_ok = 1'b0;
			end
			default: begin
				cur_x = clamp_px(cur_x, dx, settings.width);
				cur_y = clamp_px(cur_y, dy, settings.height);
				batch.push_back(make_result(KIND_MOTION, cur_x, cur_y, evt));
			end
			endcase
		end
		if (batch.size() > 0) begin
			tail = batch.pop_back();
			tail.last = 1'b1;
			batch.push_back(tail);
		end
		foreach (batch[i])
			expected_pointer.push_back(batch[i]);
	endtask

	// Offer one item, with random idle cycles first, and predict it once accepted.
	task automatic send_event(input logic [2:0] f, input logic [31:0] now,
		input logic [16:0] tx, input logic [16:0] ty, input logic [15:0] dx,
		input logic [15:0] dy);
		logic [31:0] evt;
		evt = $urandom;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		now_ms <= now;
		event_time <= evt;
		touch_x <= tx;
		touch_y <= ty;
		rel_dx <= dx;
		rel_dy <= dy;
		do
			@(posedge clk);
		while (!in_ready);
		if (f <= FUNC_ENTER)
			items_sent++;
		predict_pointer(f, now, evt, tx, ty, dx, dy);
	endtask

	// Stop offering items and let every expected result drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pointer.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
		REG_WIDTH:    settings.width = value[14:0];
		REG_HEIGHT:   settings.height = value[14:0];
		REG_ROTATED:  settings.rotated = value[0];
		REG_FOCUS:    settings.focus = value[0];
		REG_TAP_RAD:  settings.tap_radius = value[13:0];
		REG_TAP_TIME: settings.tap_time = value;
		REG_HOLD:     settings.hold_time = value;
		default:      settings.slop_radius = value[13:0];
		endcase
	endtask

	// Program all registers while the core is idle.
	task automatic load_settings(input cfg_t next);
		wait_idle();
		write_reg(REG_WIDTH, 16'(next.width));
		write_reg(REG_HEIGHT, 16'(next.height));
		write_reg(REG_ROTATED, 16'(next.rotated));
		write_reg(REG_FOCUS, 16'(next.focus));
		write_reg(REG_TAP_RAD, 16'(next.tap_radius));
		write_reg(REG_TAP_TIME, next.tap_time);
		write_reg(REG_HOLD, next.hold_time);
		write_reg(REG_SLOP, 16'(next.slop_radius));
		cfg_valid <= 1'b0;
	endtask

	// Time since touch down: short, near the tap or hold limits, or anywhere up to 70000.
	function automatic logic [31:0] pick_since();
		case ($urandom_range(3))
		0:       return 32'($urandom_range(0, 30));
		1:       return 32'(settings.tap_time) + 32'($urandom_range(0, 4)) - 32'd2;
		2:       return 32'(settings.hold_time) + 32'($urandom_range(0, 4)) - 32'd2;
		default: return 32'($urandom_range(0, 70000));
		endcase
	endfunction

	// A touch position near a given one, kept within 0 to 1.0.
	function automatic logic [16:0] near_frac(logic [16:0] base);
		int span, v;
		case ($urandom_range(2))
		0:       span = 64;
		1:       span = 1024;
		default: span = 8192;
		endcase
		v = int'(base) - span + int'($urandom_range(0, 2 * span));
		if (v < 0)
			v = 0;
		if (v > 65536)
			v = 65536;
		return 17'(v);
	endfunction

	// Down, zero to four motions, and usually a lift.
	task automatic send_gesture();
		logic [31:0] t0;
		logic [16:0] fx0, fy0;
		int moves;
		t0 = clock_ms;
		fx0 = 17'($urandom_range(0, 65536));
		fy0 = 17'($urandom_range(0, 65536));
		moves = $urandom_range(0, 4);
		send_event(FUNC_DOWN, t0, fx0, fy0, 16'($urandom), 16'($urandom));
		repeat (moves)
			send_event(FUNC_MOTION, t0 + pick_since(), near_frac(fx0), near_frac(fy0),
				16'($urandom), 16'($urandom));
		if ($urandom_range(9) != 0)
			send_event(FUNC_UP, t0 + pick_since(), near_frac(fx0), near_frac(fy0),
				16'($urandom), 16'($urandom));
		clock_ms = t0 + 32'($urandom_range(100, 80000));
	endtask

	task automatic send_rel_move();
		logic [15:0] dx, dy;
		dx = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 128) - 64);
		dy = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 128) - 64);
		send_event(FUNC_REL, clock_ms, 17'($urandom_range(0, 131071)),
			17'($urandom_range(0, 131071)), dx, dy);
	endtask

	// Without focus only the enter item acts; the unused codes never act.
	task automatic test_focus_gate();
		send_event(FUNC_DOWN, 32'd10, 17'h08000, 17'h08000, 16'd0, 16'd0);
		send_event(FUNC_REL, 32'd11, 17'h0, 17'h0, 16'd5, 16'd5);
		send_event(FUNC_ENTER, 32'd12, 17'h0, 17'h0, 16'd0, 16'd0);
		send_event(3'd5, 32'd13, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
		send_event(3'd6, 32'd14, 17'h0, 17'h0, 16'h0, 16'h0);
		send_event(3'd7, 32'd15, 17'h10000, 17'h10000, 16'h8000, 16'h7FFF);
	endtask

	// Taps, slow lifts, drags, slop cancel, edges of the surface and clock wrap.
	task automatic test_tap_and_drag();
		cfg_t next;
		next = RESET_SETTINGS;
		next.focus = 1'b1;
		load_settings(next);
		// Lift with no touch down since reset.
		send_event(FUNC_UP, 32'd1000, 17'h0, 17'h0, 16'd0, 16'd0);
		send_event(FUNC_DOWN, 32'd1000, 17'h0, 17'h0, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd1010, 17'h0, 17'h0, 16'd0, 16'd0);
		// A touch at 1.0 maps one past the last pixel; a slow lift is no tap.
		send_event(FUNC_DOWN, 32'd2000, FRAC_ONE, FRAC_ONE, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd3000, 17'h0, 17'h0, 16'd0, 16'd0);
		// Fractions above 1.0 saturate, then a drag past the hold time.
		send_event(FUNC_DOWN, 32'd4000, 17'h1FFFF, 17'h10001, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd4050, 17'h0FF00, 17'h0FF00, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd4300, 17'h0F000, 17'h0F000, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd4400, 17'h08000, 17'h08000, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd4500, 17'h0, 17'h0, 16'd0, 16'd0);
		// Moving past the slop radius early cancels the drag; a near lift still taps.
		send_event(FUNC_DOWN, 32'd5000, 17'h04000, 17'h04000, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd5010, 17'h0C000, 17'h04000, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd5020, 17'h04100, 17'h04000, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd5030, 17'h0, 17'h0, 16'd0, 16'd0);
		// Relative moves at both extremes clamp to the surface.
		send_event(FUNC_REL, 32'd6000, 17'h0, 17'h0, 16'h8000, 16'h8000);
		send_event(FUNC_REL, 32'd6001, 17'h0, 17'h0, 16'h7FFF, 16'h7FFF);
		// The millisecond clock wraps between down and lift.
		send_event(FUNC_DOWN, 32'hFFFFFFF0, 17'h02000, 17'h02000, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd5, 17'h0, 17'h0, 16'd0, 16'd0);
	endtask

	// Rotated panel with width 16384 and height 1; a drag that ends in a tap gives four results.
	task automatic test_rotated_extremes();
		cfg_t next;
		next = '{width: 15'd16384, height: 15'd1, rotated: 1'b1, focus: 1'b1,
			tap_radius: 14'd16383, tap_time: 16'd65535, hold_time: 16'd0,
			slop_radius: 14'd0};
		load_settings(next);
		send_event(FUNC_DOWN, 32'd7000, 17'h0, 17'h0, 16'd0, 16'd0);
		send_event(FUNC_MOTION, 32'd7001, 17'h00100, 17'h00100, 16'd0, 16'd0);
		send_event(FUNC_UP, 32'd7002, 17'h0, 17'h0, 16'd0, 16'd0);
		send_event(FUNC_ENTER, 32'd7003, 17'h0, 17'h0, 16'd0, 16'd0);
	endtask

	// Mostly whole gestures, with relative moves, enters, noise and broken sequences.
	task automatic test_random_gestures(input int send_pct, input int recv_pct,
		input cfg_t next, input int target);
		int start, pick;
		load_settings(next);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < target) begin
			pick = $urandom_range(99);
			if (pick < 65)
				send_gesture();
			else if (pick < 80)
				send_rel_move();
			else if (pick < 85)
				send_event(FUNC_ENTER, clock_ms, 17'h0, 17'h0, 16'd0, 16'd0);
			else if (pick < 93)
				send_event(3'($urandom_range(0, 7)), $urandom,
					17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
					16'($urandom), 16'($urandom));
			else
				send_event((pick < 96) ? 3'(FUNC_MOTION) : 3'(FUNC_UP),
					clock_ms + pick_since(), 17'($urandom_range(0, 65536)),
					17'($urandom_range(0, 65536)), 16'($urandom), 16'($urandom));
		end
	endtask

	// The result side holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		hold_requests++;
		repeat (24) begin
			if ($urandom_range(1))
				send_rel_move();
			else
				send_gesture();
		end
	endtask

	initial begin
		cfg_t plan;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_focus_gate();
		test_tap_and_drag();
		test_rotated_extremes();

		plan = RESET_SETTINGS;
		plan.focus = 1'b1;
		test_random_gestures(22, 47, plan, 55);

		plan.width = 15'($urandom_range(1, 16384));
		plan.height = 15'($urandom_range(1, 16384));
		plan.rotated = 1'b1;
		plan.tap_radius = 14'($urandom_range(0, 300));
		plan.tap_time = 16'($urandom_range(0, 400));
		plan.hold_time = 16'($urandom_range(0, 400));
		plan.slop_radius = 14'($urandom_range(0, 300));
		test_random_gestures(47, 22, plan, 55);

		plan = '{width: 15'd1, height: 15'd16384, rotated: 1'b0, focus: 1'b1,
			tap_radius: 14'd0, tap_time: 16'd0, hold_time: 16'd65535,
			slop_radius: 14'd16383};
		test_random_gestures(0, 0, plan, 55);
		test_backpressure();

		wait_idle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/ttdp_pkg.sv
rtl/ttdp_cfg.sv
rtl/ttdp_front.sv
rtl/ttdp_queue.sv
rtl/ttdp_back.sv
rtl/touch_tap_drag_to_pointer_core.sv
bench/tb_top.sv
